FILE: rtl/ifp_pkg.sv
package ifp_pkg;

  localparam logic [7:0]  HdrByte    = 8'h55;
  localparam logic [7:0]  KindAcc    = 8'h51;
  localparam logic [7:0]  KindAng    = 8'h53;
  localparam int unsigned DataLen    = 8;
  localparam int unsigned PosW       = $clog2(DataLen);
  localparam logic [15:0] LimitReset = 16'd5000;
  localparam logic [15:0] CountMax   = 16'hFFFF;

  localparam int unsigned UserW = 4;
  localparam int unsigned DataW = 64;

  // tuser bit positions
  localparam int unsigned UserOkBit      = 2;
  localparam int unsigned UserRestartBit = 3;

  typedef enum logic [3:0] {
    PhHunt = 4'b0001,
    PhType = 4'b0010,
    PhData = 4'b0100,
    PhSum  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [UserW-1:0] user;
    logic [DataW-1:0] data;
  } result_t;

endpackage

FILE: rtl/imu_frame_parser.sv
// Frame parser for an inertial sensor byte stream. It takes one received byte
// per accepted word, hunts for the 0x55 header and a 0x51/0x52/0x53 type byte,
// gathers eight data bytes and checks the trailing sum byte. One result word
// leaves per completed frame with the kind, four signed little-endian data
// words and the checksum verdict; bad frames advance a saturating failure
// counter, and when that counter exceeds failure_limit the result carries a
// restart request and the counter clears. A byte may enter on every clock:
// parse state updates in the accept cycle and the result lands in an output
// register backed by one skid register, so the input stalls only when both
// hold results the sink has not taken.
module imu_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // failure_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // word_a, word_b, word_c, word_d
  output logic [3:0]  m_axis_tuser    // frame_kind[1:0], checksum_ok, restart_request
);

  ifp_pkg::phase_e            phase_q, phase_d;
  logic [ifp_pkg::PosW:0]     pos_q, pos_d;
  logic [7:0]                 sum_q, sum_d;
  logic [1:0]                 kind_q, kind_d;
  logic [7:0]                 data_q [ifp_pkg::DataLen];
  logic [15:0]                fail_cnt_q, fail_cnt_d;
  logic [15:0]                limit_q;

  ifp_pkg::result_t           out_q, out_d, skid_q, skid_d, res;
  logic                       out_v_q, out_v_d, skid_v_q, skid_v_d;

  logic                       in_acc, emit, ok, restart;
  logic [15:0]                cnt_bumped;
  logic [7:0]                 sum_next;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_v_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign emit          = in_acc && (phase_q == ifp_pkg::PhSum);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.user;

  assign sum_next   = sum_q + s_axis_tdata;
  assign ok         = (sum_q == s_axis_tdata);
  assign cnt_bumped = (ok || fail_cnt_q == ifp_pkg::CountMax) ? fail_cnt_q
                                                              : fail_cnt_q + 16'd1;
  assign restart    = (cnt_bumped > limit_q);

  always_comb begin
    res.data = {data_q[7], data_q[6], data_q[5], data_q[4],
                data_q[3], data_q[2], data_q[1], data_q[0]};
    res.user = {restart, ok, kind_q};
  end

  // parse state
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    kind_d     = kind_q;
    fail_cnt_d = fail_cnt_q;
    if (in_acc) begin
      case (phase_q)
        ifp_pkg::PhHunt: begin
          if (s_axis_tdata == ifp_pkg::HdrByte) begin
            sum_d   = ifp_pkg::HdrByte;
            phase_d = ifp_pkg::PhType;
          end
        end
        ifp_pkg::PhType: begin
          if (s_axis_tdata >= ifp_pkg::KindAcc && s_axis_tdata <= ifp_pkg::KindAng) begin
            kind_d  = 2'(s_axis_tdata - ifp_pkg::KindAcc);
            sum_d   = sum_next;
            pos_d   = '0;
            phase_d = ifp_pkg::PhData;
          end else if (s_axis_tdata == ifp_pkg::HdrByte) begin
            sum_d = ifp_pkg::HdrByte;
          end else begin
            phase_d = ifp_pkg::PhHunt;
          end
        end
        ifp_pkg::PhData: begin
          sum_d = sum_next;
          pos_d = pos_q + 1'b1;
          if (pos_q == (ifp_pkg::PosW+1)'(ifp_pkg::DataLen - 1)) begin
            phase_d = ifp_pkg::PhSum;
          end
        end
        ifp_pkg::PhSum: begin
          fail_cnt_d = restart ? '0 : cnt_bumped;
          phase_d    = ifp_pkg::PhHunt;
          pos_d      = '0;
          sum_d      = '0;
        end
        default: begin
          phase_d = ifp_pkg::PhHunt;
        end
      endcase
    end
  end

  // output register with one skid word behind it
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = res;
        out_v_d = emit;
      end
    end else if (emit) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ifp_pkg::PhHunt;
      pos_q      <= '0;
      sum_q      <= '0;
      kind_q     <= '0;
      fail_cnt_q <= '0;
      limit_q    <= ifp_pkg::LimitReset;
      out_v_q    <= 1'b0;
      skid_v_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      kind_q     <= kind_d;
      fail_cnt_q <= fail_cnt_d;
      out_v_q    <= out_v_d;
      skid_v_q   <= skid_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
    if (in_acc && phase_q == ifp_pkg::PhData) begin
      data_q[pos_q[ifp_pkg::PosW-1:0]] <= s_axis_tdata;
    end
  end

endmodule

FILE: rtl/ifp_checker.sv
module ifp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // hold a stalled word
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'b11)
    else $error("frame kind out of range");

endmodule

bind imu_frame_parser ifp_checker u_ifp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
